// ===== sv/oled_command_and_gddram_decoder_top_assert.svh =====
// Assertion macros for the OLED decoder RTL.
// Expects clk and rst in scope at the point of use.
`ifndef OLED_COMMAND_AND_GDDRAM_DECODER_TOP_ASSERT_SVH
`define OLED_COMMAND_AND_GDDRAM_DECODER_TOP_ASSERT_SVH

// same-cycle implication
`define OCGD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define OCGD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/ocgd_pkg.sv =====
// Shared types, codes and constants for the OLED command / frame store decoder.
// No dependencies.
package ocgd_pkg;

  localparam int COLUMNS_DEF = 128;
  localparam int PAGES_DEF   = 8;
  localparam int RADDR_W     = 10;
  localparam int FULL_FRAME  = 1024;

  // control bytes
  localparam logic [7:0] CTRL_CMD  = 8'h00;
  localparam logic [7:0] CTRL_DATA = 8'h40;

  // command opcodes
  localparam logic [7:0] OP_COL_ADDR  = 8'h21;
  localparam logic [7:0] OP_PAGE_ADDR = 8'h22;
  localparam logic [7:0] OP_HOME      = 8'h7F;
  localparam logic [7:0] OP_DISP_OFF  = 8'hAE;
  localparam logic [7:0] OP_DISP_ON   = 8'hAF;
  localparam logic [7:0] OP_NORMAL    = 8'hA6;
  localparam logic [7:0] OP_INVERT    = 8'hA7;
  localparam logic [7:0] OP_CLK_DIV   = 8'hD5;
  localparam logic [7:0] OP_MUX       = 8'hA8;
  localparam logic [7:0] OP_PUMP      = 8'h8D;
  localparam logic [7:0] OP_CONTRAST  = 8'h81;
  localparam logic [7:0] OP_OFFSET    = 8'hD3;
  localparam logic [7:0] OP_NONE      = 8'h00;
  localparam logic [4:0] OP_PAGE_SEL  = 5'h16;  // 0xB0..0xB7 upper bits
  localparam logic [7:0] PUMP_ON_VAL  = 8'h14;

  typedef struct packed {
    logic                cmd;
    logic                first_of_transfer;
    logic [7:0]          bus_byte;
    logic [RADDR_W-1:0]  read_address;
  } in_beat_t;

  // decoder status after a step
  typedef struct packed {
    logic       frame_ready;
    logic       display_on;
    logic       inverted;
    logic [3:0] clock_divide;
    logic [3:0] oscillator_freq;
    logic [5:0] multiplex;
    logic       pump_enabled;
    logic [5:0] vertical_offset;
    logic [2:0] current_page;
    logic [6:0] current_column;
  } status_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       frame_ready;
    logic       display_on;
    logic       inverted;
    logic [3:0] clock_divide;
    logic [3:0] oscillator_freq;
    logic [5:0] multiplex;
    logic       pump_enabled;
    logic [5:0] vertical_offset;
    logic [2:0] current_page;
    logic [6:0] current_column;
  } out_beat_t;

endpackage

// ===== sv/ocgd_if.sv =====
// Valid/ready channel interfaces for request and response beats.
// Depends on ocgd_pkg.
interface ocgd_req_if import ocgd_pkg::*; ();
  logic     valid;
  logic     ready;
  in_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ocgd_rsp_if import ocgd_pkg::*; ();
  logic      valid;
  logic      ready;
  out_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ocgd_frame_mem.sv =====
// Frame store: one write port, one read port with registered read data.
// No package dependencies.
module ocgd_frame_mem #(
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // read sees the old contents on a same-cycle write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/ocgd_decoder.sv =====
// Bus byte decoder: stream mode, command parameters, pointers, settings.
// Depends on ocgd_pkg; drives the frame store write port.
module ocgd_decoder import ocgd_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int PAGES   = PAGES_DEF,
  parameter int AW      = $clog2(COLUMNS * PAGES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  logic          first,
  input  logic [7:0]    bus_byte,
  output status_t       st,
  output logic          we,
  output logic [AW-1:0] waddr,
  output logic [7:0]    wdata
);

  localparam int CW     = $clog2(COLUMNS);
  localparam int PW     = (PAGES > 1) ? $clog2(PAGES) : 1;
  localparam int DCNT_W = $clog2(FULL_FRAME);

  typedef enum logic [1:0] {MODE_AWAIT, MODE_CMD, MODE_DATA} mode_t;

  typedef logic [CW-1:0] col_tab_t [256];
  typedef logic [PW-1:0] pg_tab_t  [256];

  function automatic col_tab_t col_table();
    col_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = CW'(i % COLUMNS);
    return t;
  endfunction

  function automatic pg_tab_t pg_table();
    pg_tab_t t;
    for (int i = 0; i < 256; i++) t[i] = PW'(i % PAGES);
    return t;
  endfunction

  localparam col_tab_t COL_MOD = col_table();
  localparam pg_tab_t  PG_MOD  = pg_table();

  mode_t              mode, mode_next, md;
  logic [7:0]         pcmd, pcmd_next;
  logic [1:0]         pcnt, pcnt_next;
  logic [7:0]         hold, hold_next;
  logic [CW-1:0]      wsc, wsc_next, cp, cp_next;
  logic [PW-1:0]      wsp, wsp_next, pp, pp_next;
  logic [DCNT_W-1:0]  dcnt, dcnt_next;
  logic               on, on_next, inv, inv_next, pump, pump_next;
  logic [3:0]         cdiv, cdiv_next, osc, osc_next;
  logic [5:0]         mux, mux_next, voff, voff_next;
  logic               ready;
  logic [CW:0]        cp_inc;
  logic [PW:0]        pp_inc;
  logic [AW:0]        pos;

  assign pos    = (AW+1)'(pp) * (AW+1)'(COLUMNS) + (AW+1)'(cp);
  assign cp_inc = {1'b0, cp} + 1'b1;
  assign pp_inc = {1'b0, pp} + 1'b1;
  assign waddr  = AW'(pos);
  assign wdata  = bus_byte;

  always_comb begin
    mode_next = mode;  pcmd_next = pcmd;  pcnt_next = pcnt;  hold_next = hold;
    wsc_next  = wsc;   wsp_next  = wsp;   cp_next   = cp;    pp_next   = pp;
    dcnt_next = dcnt;  on_next   = on;    inv_next  = inv;   pump_next = pump;
    cdiv_next = cdiv;  osc_next  = osc;   mux_next  = mux;   voff_next = voff;
    ready     = 1'b0;
    we        = 1'b0;
    md        = mode;
    if (step) begin
      if (first) begin
        pcnt_next = '0;
        pcmd_next = OP_NONE;
        md        = MODE_AWAIT;
      end
      mode_next = md;
      case (md)
        MODE_AWAIT: begin
          if (bus_byte == CTRL_DATA) mode_next = MODE_DATA;
          else if (bus_byte == CTRL_CMD) mode_next = MODE_CMD;
        end
        MODE_CMD: begin
          if (pcnt != 2'd0) begin
            pcnt_next = pcnt - 2'd1;
            case (pcmd)
              OP_COL_ADDR: begin
                if (pcnt == 2'd2) hold_next = bus_byte;
                else begin
                  wsc_next = COL_MOD[hold];
                  cp_next  = COL_MOD[hold];
                end
              end
              OP_PAGE_ADDR: begin
                if (pcnt == 2'd2) hold_next = bus_byte;
                else begin
                  wsp_next = PG_MOD[hold];
                  pp_next  = PG_MOD[hold];
                end
              end
              OP_CLK_DIV: begin
                cdiv_next = bus_byte[3:0];
                osc_next  = bus_byte[7:4];
              end
              OP_MUX:    mux_next  = bus_byte[5:0];
              OP_OFFSET: voff_next = bus_byte[5:0];
              OP_PUMP:   pump_next = (bus_byte == PUMP_ON_VAL);
              default: ;
            endcase
          end else begin
            case (bus_byte)
              CTRL_CMD: ;
              CTRL_DATA: mode_next = MODE_DATA;
              OP_COL_ADDR, OP_PAGE_ADDR: begin
                pcmd_next = bus_byte;
                pcnt_next = 2'd2;
              end
              OP_CLK_DIV, OP_MUX, OP_PUMP, OP_CONTRAST, OP_OFFSET: begin
                pcmd_next = bus_byte;
                pcnt_next = 2'd1;
              end
              OP_HOME: begin
                cp_next = wsc;
                pp_next = wsp;
              end
              OP_DISP_OFF: on_next = 1'b0;
              OP_DISP_ON: begin
                on_next   = 1'b1;
                dcnt_next = '0;
                ready     = 1'b1;
              end
              OP_NORMAL: inv_next = 1'b0;
              OP_INVERT: inv_next = 1'b1;
              default: begin
                if (bus_byte[7:3] == OP_PAGE_SEL) pp_next = PG_MOD[{5'b0, bus_byte[2:0]}];
              end
            endcase
          end
        end
        MODE_DATA: begin
          we = 1'b1;
          if (cp_inc >= (CW+1)'(COLUMNS)) begin
            cp_next = wsc;
            if (pp_inc >= (PW+1)'(PAGES)) pp_next = wsp;
            else pp_next = PW'(pp_inc);
          end else begin
            cp_next = CW'(cp_inc);
          end
          dcnt_next = dcnt + 1'b1;  // wraps at a full frame
          ready     = (dcnt == DCNT_W'(FULL_FRAME - 1));
        end
        default: mode_next = MODE_AWAIT;
      endcase
    end
  end

  always_comb begin
    st.frame_ready     = ready;
    st.display_on      = on_next;
    st.inverted        = inv_next;
    st.clock_divide    = cdiv_next;
    st.oscillator_freq = osc_next;
    st.multiplex       = mux_next;
    st.pump_enabled    = pump_next;
    st.vertical_offset = voff_next;
    st.current_page    = 3'(pp_next);
    st.current_column  = 7'(cp_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_AWAIT;  pcmd <= OP_NONE;  pcnt <= '0;  hold <= '0;
      wsc  <= '0;  wsp  <= '0;  cp   <= '0;  pp   <= '0;  dcnt <= '0;
      on   <= 1'b1;  inv <= 1'b0;  pump <= 1'b0;
      cdiv <= '0;  osc  <= '0;  mux  <= '0;  voff <= '0;
    end else begin
      mode <= mode_next;  pcmd <= pcmd_next;  pcnt <= pcnt_next;  hold <= hold_next;
      wsc  <= wsc_next;   wsp  <= wsp_next;   cp   <= cp_next;    pp   <= pp_next;
      dcnt <= dcnt_next;  on   <= on_next;    inv  <= inv_next;   pump <= pump_next;
      cdiv <= cdiv_next;  osc  <= osc_next;   mux  <= mux_next;   voff <= voff_next;
    end
  end

endmodule

// ===== sv/oled_command_and_gddram_decoder_top.sv =====
// Top level of the OLED command and frame store decoder.
// Depends on ocgd_pkg, ocgd_if, ocgd_decoder, ocgd_frame_mem and the assert header.
//
//   channel | dir | payload    | beat
//   --------+-----+------------+-------------------------------------------
//   req     | in  | in_beat_t  | one bus byte or one frame read request
//   rsp     | out | out_beat_t | one result per request, in request order
//
// Throughput: one beat per cycle sustained; the decoder updates its control
//   registers and the frame store write port in the accept cycle.
// Path: an accepted request is registered in the address reduction stage,
//   then in the output register, beside the registered frame store read port.
// Reset: a clearing pass zeroes all COLUMNS*PAGES frame store locations
//   (1024 at the default geometry); req.ready stays low meanwhile.
// Stalls: a held rsp beat freezes the whole pipeline and req.ready drops.
`include "oled_command_and_gddram_decoder_top_assert.svh"

module oled_command_and_gddram_decoder_top import ocgd_pkg::*; #(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int PAGES   = PAGES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  ocgd_req_if.sink   req,
  ocgd_rsp_if.source rsp
);

  localparam int STORE = COLUMNS * PAGES;
  localparam int AW    = $clog2(STORE);
  // reciprocal for read_address mod STORE, exact over the 10-bit range
  localparam int RK    = RADDR_W + $clog2(STORE);
  localparam int RM    = ((2 ** RK) + STORE - 1) / STORE;
  localparam int MW    = RADDR_W + 2;
  localparam int PRW   = RADDR_W + MW;
  localparam int ZW    = RADDR_W + AW + 1;

  // clearing pass after reset
  logic          clearing;
  logic [AW-1:0] clr_cnt;

  // pipeline control
  logic adv, acc, step;
  assign adv       = !rsp.valid || rsp.ready;
  assign req.ready = adv && !clearing;
  assign acc       = req.valid && req.ready;
  assign step      = acc && !req.data.cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_cnt  <= '0;
    end else if (clearing) begin
      clr_cnt <= clr_cnt + 1'b1;
      if (clr_cnt == AW'(STORE - 1)) clearing <= 1'b0;
    end
  end

  // decoder
  status_t       dec_st;
  logic          dec_we;
  logic [AW-1:0] dec_waddr;
  logic [7:0]    dec_wdata;

  ocgd_decoder #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_dec (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .first    (req.data.first_of_transfer),
    .bus_byte (req.data.bus_byte),
    .st       (dec_st),
    .we       (dec_we),
    .waddr    (dec_waddr),
    .wdata    (dec_wdata)
  );

  // quotient estimate in the accept cycle
  logic [PRW-1:0]     prod;
  logic [RADDR_W-1:0] q_in;
  assign prod = PRW'(req.data.read_address) * PRW'(RM);
  assign q_in = RADDR_W'(prod >> RK);

  // stage 1: request registered, remainder drives the read port
  logic               s1_valid, s1_read;
  status_t            s1_st;
  logic [RADDR_W-1:0] s1_a, s1_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && acc) begin
      s1_read <= req.data.cmd;
      s1_st   <= dec_st;
      s1_a    <= req.data.read_address;
      s1_q    <= q_in;
    end
  end

  logic [ZW-1:0] rem_full;
  logic [AW-1:0] rd_addr;
  assign rem_full = ZW'(s1_a) - ZW'(s1_q) * ZW'(STORE);
  assign rd_addr  = AW'(rem_full);

  // frame store
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata, mem_rdata;

  assign mem_we    = clearing || dec_we;
  assign mem_waddr = clearing ? clr_cnt : dec_waddr;
  assign mem_wdata = clearing ? 8'h00 : dec_wdata;
  assign mem_re    = adv && s1_valid && s1_read;

  ocgd_frame_mem #(
    .DEPTH (STORE)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  // output register
  logic    o_read;
  status_t o_st;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (adv) begin
      rsp.valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid) begin
      o_read <= s1_read;
      o_st   <= s1_st;
    end
  end

  // inversion reflects the state in force at the read
  always_comb begin
    rsp.data.read_data       = o_read ? (mem_rdata ^ {8{o_st.inverted}}) : 8'h00;
    rsp.data.frame_ready     = o_st.frame_ready;
    rsp.data.display_on      = o_st.display_on;
    rsp.data.inverted        = o_st.inverted;
    rsp.data.clock_divide    = o_st.clock_divide;
    rsp.data.oscillator_freq = o_st.oscillator_freq;
    rsp.data.multiplex       = o_st.multiplex;
    rsp.data.pump_enabled    = o_st.pump_enabled;
    rsp.data.vertical_offset = o_st.vertical_offset;
    rsp.data.current_page    = o_st.current_page;
    rsp.data.current_column  = o_st.current_column;
  end

  `OCGD_ASSERT_NOW(a_no_accept_clearing, clearing, !req.ready, "request accepted during clear")
  `OCGD_ASSERT_NOW(a_no_dec_write_clearing, clearing, !dec_we, "decoder write during clear")
  `OCGD_ASSERT_NOW(a_rd_addr_range, s1_valid && s1_read, rem_full < ZW'(STORE), "read index range")
  `OCGD_ASSERT_NEXT(a_s1_hold, s1_valid && !adv, s1_valid, "stage 1 beat lost under stall")
  `OCGD_ASSERT_NOW(a_ready_only_bus, rsp.valid && o_read, !rsp.data.frame_ready, "ready on read")

endmodule

// ===== bench/oled_command_and_gddram_decoder_top_test.sv =====
// Self-checking bench for oled_command_and_gddram_decoder_top: byte stream decode and frame reads.
// Depends on ocgd_pkg, ocgd_if and the decoder RTL; predicts every response beat itself.
module oled_command_and_gddram_decoder_top_test;
  import ocgd_pkg::*;

  localparam int COLS         = COLUMNS_DEF;
  localparam int PGS          = PAGES_DEF;
  localparam int STORE_BYTES  = COLS * PGS;
  localparam int RANDOM_BEATS = 550;
  localparam int REPORT_LIMIT = 10;

  // where the byte stream currently stands
  typedef enum logic [1:0] {AWAIT_CTRL, IN_COMMAND, IN_DATA} stream_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic sink_ready = 1'b0;

  ocgd_req_if req_ch ();
  ocgd_rsp_if rsp_ch ();

  assign rsp_ch.ready = sink_ready;

  oled_command_and_gddram_decoder_top uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the decoder state
  // ---------------------------------------------------------------------------
  logic [7:0] shadow_frame [STORE_BYTES];
  stream_t    strm;
  logic [7:0] held_opcode;
  int         params_left;
  logic [7:0] first_param;
  int         win_col, win_page;
  int         col_ptr, page_ptr;
  int         bytes_since_frame;
  logic       disp_on, invert_on, pump_on;
  logic [3:0] clk_div, osc_nibble;
  logic [5:0] mux_ratio, row_offset;

  out_beat_t expected_results [$];

  int  beats_sent  = 0;
  int  fail_count  = 0;
  bit  steady_flow = 1'b0;  // no new idling on either side while set
  bit  mix_reads   = 1'b0;  // sprinkle frame reads between bus bytes

  // Applies one request beat to the shadow state and returns the response it causes.
  function automatic out_beat_t predict_status(in_beat_t b);
    out_beat_t  r;
    logic [7:0] bb;
    logic       pulse;
    r     = '0;
    bb    = b.bus_byte;
    pulse = 1'b0;
    if (b.cmd) begin
      // reads touch nothing; the address is always inside the store at this geometry
      r.read_data = shadow_frame[b.read_address % STORE_BYTES] ^ (invert_on ? 8'hFF : 8'h00);
    end else begin
      if (b.first_of_transfer) begin
        // a new transfer drops any command still waiting on parameters
        params_left = 0;
        held_opcode = OP_NONE;
        strm        = AWAIT_CTRL;
      end
      case (strm)
        AWAIT_CTRL: begin
          // unknown control bytes leave us waiting; the next byte is looked at again
          if (bb == CTRL_DATA) strm = IN_DATA;
          else if (bb == CTRL_CMD) strm = IN_COMMAND;
        end
        IN_COMMAND: begin
          if (params_left != 0) begin
            // parameter bytes are taken as is, even 0x00 and 0x40
            case (held_opcode)
              OP_COL_ADDR: begin
                if (params_left == 2) begin
                  first_param = bb;
                end else begin
                  win_col = first_param % COLS;
                  col_ptr = win_col;
                end
              end
              OP_PAGE_ADDR: begin
                if (params_left == 2) begin
                  first_param = bb;
                end else begin
                  win_page = first_param % PGS;
                  page_ptr = win_page;
                end
              end
              OP_CLK_DIV: begin
                clk_div    = bb[3:0];
                osc_nibble = bb[7:4];
              end
              OP_MUX:    mux_ratio  = bb[5:0];
              OP_OFFSET: row_offset = bb[5:0];
              OP_PUMP:   pump_on    = (bb == PUMP_ON_VAL);
              default: ;
            endcase
            params_left--;
          end else if (bb == CTRL_CMD) begin
            // stray command control byte: skipped
          end else if (bb == CTRL_DATA) begin
            strm = IN_DATA;
          end else begin
            case (bb)
              OP_COL_ADDR, OP_PAGE_ADDR: begin
                held_opcode = bb;
                params_left = 2;
              end
              OP_CLK_DIV, OP_MUX, OP_PUMP, OP_CONTRAST, OP_OFFSET: begin
                held_opcode = bb;
                params_left = 1;
              end
              OP_HOME: begin
                col_ptr  = win_col;
                page_ptr = win_page;
              end
              OP_DISP_OFF: disp_on = 1'b0;
              OP_DISP_ON: begin
                disp_on           = 1'b1;
                bytes_since_frame = 0;
                pulse             = 1'b1;
              end
              OP_NORMAL: invert_on = 1'b0;
              OP_INVERT: invert_on = 1'b1;
              default: begin
                if (bb[7:3] == OP_PAGE_SEL) page_ptr = bb[2:0] % PGS;
              end
            endcase
          end
        end
        default: begin
          // data byte: write, advance with wrap inside the window
          shadow_frame[page_ptr * COLS + col_ptr] = bb;
          col_ptr++;
          if (col_ptr >= COLS) begin
            col_ptr = win_col;
            page_ptr++;
            if (page_ptr >= PGS) page_ptr = win_page;
          end
          bytes_since_frame++;
          if (bytes_since_frame >= FULL_FRAME) begin
            bytes_since_frame = 0;
            pulse             = 1'b1;
          end
        end
      endcase
    end
    r.frame_ready     = pulse;
    r.display_on      = disp_on;
    r.inverted        = invert_on;
    r.clock_divide    = clk_div;
    r.oscillator_freq = osc_nibble;
    r.multiplex       = mux_ratio;
    r.pump_enabled    = pump_on;
    r.vertical_offset = row_offset;
    r.current_page    = page_ptr[2:0];
    r.current_column  = col_ptr[6:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Idling
  // ---------------------------------------------------------------------------
  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 14) return $urandom_range(1, 3);
    if (r < 19) return $urandom_range(4, 8);
    return $urandom_range(20, 40);
  endfunction

  // sink side: random stalls, held for a random number of cycles
  int sink_hold = 0;
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
    end else if (!steady_flow && $urandom_range(0, 3) == 0) begin
      sink_ready <= 1'b0;
      sink_hold  <= pick_gap();
    end else begin
      sink_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Sending
  // ---------------------------------------------------------------------------
  // Called at a rising edge. Valid is left high after the beat goes so that a
  // back-to-back beat needs only one assignment in that step.
  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = (steady_flow || $urandom_range(0, 2) != 0) ? 0 : pick_gap();
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= b;
    // ready is stable at the falling edge; it decides the next rising edge
    forever begin
      @(negedge clk);
      if (req_ch.ready === 1'b1) break;
    end
    @(posedge clk);
    expected_results.push_back(predict_status(b));
    beats_sent++;
  endtask

  task automatic read_beat(input logic [RADDR_W-1:0] addr);
    in_beat_t b;
    b.cmd               = 1'b1;
    b.first_of_transfer = 1'($urandom_range(0, 1));
    b.bus_byte          = 8'($urandom_range(0, 255));
    b.read_address      = addr;
    send_beat(b);
  endtask

  task automatic bus_beat(input logic first, input logic [7:0] value);
    in_beat_t b;
    if (mix_reads && $urandom_range(0, 7) == 0) read_beat(10'($urandom_range(0, 1023)));
    b.cmd               = 1'b0;
    b.first_of_transfer = first;
    b.bus_byte          = value;
    b.read_address      = 10'($urandom_range(0, 1023));
    send_beat(b);
  endtask

  // sender holds off until every outstanding response is back
  task automatic drain_responses();
    req_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0);
  endtask

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= REPORT_LIMIT) $display("ERROR: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) note_failure($sformatf("%s expected %h, got %h", name, want, got));
  endtask

  out_beat_t want_beat;
  out_beat_t got_beat;
  always @(negedge clk) begin
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got_beat = rsp_ch.data;
      if (expected_results.size() == 0) begin
        note_failure("response beat with nothing outstanding");
      end else begin
        want_beat = expected_results.pop_front();
        check_field("read_data", want_beat.read_data, got_beat.read_data);
        check_field("frame_ready", want_beat.frame_ready, got_beat.frame_ready);
        check_field("display_on", want_beat.display_on, got_beat.display_on);
        check_field("inverted", want_beat.inverted, got_beat.inverted);
        check_field("clock_divide", want_beat.clock_divide, got_beat.clock_divide);
        check_field("oscillator_freq", want_beat.oscillator_freq, got_beat.oscillator_freq);
        check_field("multiplex", want_beat.multiplex, got_beat.multiplex);
        check_field("pump_enabled", want_beat.pump_enabled, got_beat.pump_enabled);
        check_field("vertical_offset", want_beat.vertical_offset, got_beat.vertical_offset);
        check_field("current_page", want_beat.current_page, got_beat.current_page);
        check_field("current_column", want_beat.current_column, got_beat.current_column);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers for the random part
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] pick_opcode();
    case ($urandom_range(0, 14))
      0:  return OP_COL_ADDR;
      1:  return OP_PAGE_ADDR;
      2:  return OP_HOME;
      3:  return OP_DISP_OFF;
      4:  return OP_DISP_ON;
      5:  return OP_NORMAL;
      6:  return OP_INVERT;
      7:  return OP_CLK_DIV;
      8:  return OP_MUX;
      9:  return OP_PUMP;
      10: return OP_CONTRAST;
      11: return OP_OFFSET;
      12: return {OP_PAGE_SEL, 3'($urandom_range(0, 7))};
      13: return CTRL_CMD;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int params_of(input logic [7:0] op);
    case (op)
      OP_COL_ADDR, OP_PAGE_ADDR: return 2;
      OP_CLK_DIV, OP_MUX, OP_PUMP, OP_CONTRAST, OP_OFFSET: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic logic [7:0] param_for(input logic [7:0] op);
    if (op == OP_PUMP && $urandom_range(0, 1) == 0) return PUMP_ON_VAL;
    case ($urandom_range(0, 7))
      0: return CTRL_CMD;   // parameters that look like control bytes
      1: return CTRL_DATA;
      2: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // well-formed command transfer; the last command is cut short now and then
  task automatic command_transfer();
    int n, cnt;
    logic [7:0] op;
    bus_beat(1'b1, CTRL_CMD);
    n = $urandom_range(1, 6);
    for (int i = 0; i < n; i++) begin
      op  = pick_opcode();
      cnt = params_of(op);
      bus_beat(1'b0, op);
      if (i == n - 1 && cnt > 0 && $urandom_range(0, 5) == 0) cnt = $urandom_range(0, cnt - 1);
      repeat (cnt) bus_beat(1'b0, param_for(op));
    end
  endtask

  // data transfer, sometimes entered through 0x40 inside command mode
  task automatic data_transfer();
    if ($urandom_range(0, 3) == 0) begin
      bus_beat(1'b1, CTRL_CMD);
      bus_beat(1'b0, CTRL_DATA);
    end else begin
      bus_beat(1'b1, CTRL_DATA);
    end
    repeat ($urandom_range(1, 12)) bus_beat(1'b0, 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // all commands but display on and normal, with parameter extremes and parameters equal to control bytes
  task automatic test_command_set();
    bus_beat(1'b1, CTRL_CMD);
    bus_beat(1'b0, OP_COL_ADDR);
    bus_beat(1'b0, CTRL_DATA);          // start column 64, taken as parameter
    bus_beat(1'b0, CTRL_CMD);           // end column, ignored
    bus_beat(1'b0, OP_PAGE_ADDR);
    bus_beat(1'b0, 8'hFF);              // start page wraps to 7
    bus_beat(1'b0, CTRL_CMD);
    bus_beat(1'b0, {OP_PAGE_SEL, 3'd3});
    bus_beat(1'b0, OP_HOME);
    bus_beat(1'b0, OP_CLK_DIV);
    bus_beat(1'b0, 8'hFF);
    bus_beat(1'b0, OP_MUX);
    bus_beat(1'b0, 8'hFF);
    bus_beat(1'b0, OP_OFFSET);
    bus_beat(1'b0, 8'hFF);
    bus_beat(1'b0, OP_PUMP);
    bus_beat(1'b0, PUMP_ON_VAL);
    bus_beat(1'b0, OP_CONTRAST);
    bus_beat(1'b0, CTRL_DATA);
    bus_beat(1'b0, OP_INVERT);
    bus_beat(1'b0, OP_DISP_OFF);
    bus_beat(1'b0, CTRL_CMD);           // skipped outside a parameter
    bus_beat(1'b0, CTRL_DATA);          // switches to data mode
  endtask

  // data at the window corner, then reads at both ends of the store (inverted)
  task automatic test_data_and_reads();
    bus_beat(1'b0, 8'hFF);
    bus_beat(1'b0, 8'h00);
    read_beat(10'd1023);
    read_beat(10'd0);
    read_beat(10'(7 * COLS + 64));
  endtask

  // truncated command, unknown control byte, display on, pump off
  task automatic test_stream_corners();
    bus_beat(1'b1, CTRL_CMD);
    bus_beat(1'b0, OP_COL_ADDR);
    bus_beat(1'b1, 8'h55);              // cuts the column command; unknown control
    bus_beat(1'b0, CTRL_CMD);           // examined as a control byte again
    bus_beat(1'b0, OP_DISP_ON);
    bus_beat(1'b0, OP_NORMAL);
    bus_beat(1'b0, OP_PUMP);
    bus_beat(1'b0, 8'h00);
  endtask

  // a full frame from the origin plus a few more bytes to see the count restart
  task automatic test_full_frame();
    bus_beat(1'b1, CTRL_CMD);
    bus_beat(1'b0, OP_PAGE_ADDR);
    bus_beat(1'b0, 8'h00);
    bus_beat(1'b0, 8'h07);
    bus_beat(1'b0, OP_COL_ADDR);
    bus_beat(1'b0, 8'h00);
    bus_beat(1'b0, 8'h7F);
    bus_beat(1'b1, CTRL_DATA);
    repeat (FULL_FRAME + 6) bus_beat(1'b0, 8'($urandom_range(0, 255)));
    repeat (8) read_beat(10'($urandom_range(0, 1023)));
  endtask

  task automatic test_random_traffic();
    int start, sel;
    start     = beats_sent;
    mix_reads = 1'b1;
    while (beats_sent - start < RANDOM_BEATS) begin
      steady_flow = ($urandom_range(0, 9) == 0);
      sel = $urandom_range(0, 99);
      if (sel < 55) command_transfer();
      else if (sel < 80) data_transfer();
      else if (sel < 92) repeat ($urandom_range(1, 4)) read_beat(10'($urandom_range(0, 1023)));
      else bus_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
      if (sel == 99) drain_responses();
    end
    mix_reads   = 1'b0;
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    req_ch.valid = 1'b0;
    req_ch.data  = '0;
    // shadow state at reset
    foreach (shadow_frame[i]) shadow_frame[i] = 8'h00;
    strm              = AWAIT_CTRL;
    held_opcode       = OP_NONE;
    params_left       = 0;
    first_param       = 8'h00;
    win_col           = 0;
    win_page          = 0;
    col_ptr           = 0;
    page_ptr          = 0;
    bytes_since_frame = 0;
    disp_on           = 1'b1;
    invert_on         = 1'b0;
    pump_on           = 1'b0;
    clk_div           = '0;
    osc_nibble        = '0;
    mux_ratio         = '0;
    row_offset        = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    // the clearing pass after reset holds req.ready low; the sender just waits

    test_command_set();
    test_data_and_reads();
    drain_responses();
    test_stream_corners();
    test_full_frame();
    drain_responses();
    test_random_traffic();

    drain_responses();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("oled_command_and_gddram_decoder_top_test OK");
    end else begin
      $display("oled_command_and_gddram_decoder_top_test NOT OK");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #(12 * 1000000);
    $display("oled_command_and_gddram_decoder_top_test NOT OK");
    $finish;
  end

endmodule
